// ----- hw/rtl/swt_pkg.sv -----
// Shared types, codes and constants of the stereo pixel/world transform.
// No dependencies.
`default_nettype none
package swt_pkg;

   localparam int COEF_W      = 32;
   localparam int MAT_ENTRIES = 12;
   localparam int STORE_DEPTH = 13;
   localparam int SCALE_INDEX = 12;
   localparam int RES_W       = 32;

   localparam logic [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};
   localparam logic [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};

   typedef enum logic [1:0] {
      ACT_LOAD = 2'd0,
      ACT_BACK = 2'd1,
      ACT_PROJ = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_ZERO_DISP = 2'd1,
      ST_SINGULAR  = 2'd2
   } status_type;

   // front-end word: snapshot of the matrix plus coordinates
   typedef struct packed {
      action_type                            action;
      logic                                  disp_zero;
      logic                                  s_neg;
      logic [MAT_ENTRIES-1:0][COEF_W-1:0]    m;
      logic [COEF_W-1:0]                     px;
      logic [COEF_W-1:0]                     py;
      logic [COEF_W-1:0]                     wx;
      logic [COEF_W-1:0]                     wy;
      logic [COEF_W-1:0]                     wz;
   } item_type;

   // back-end flags that ride alongside the quotient dividers
   typedef struct packed {
      action_type action;
      logic       disp_zero;
      logic       depth_zero;
      logic       singular;
      logic [2:0] neg;
   } meta_type;

   function automatic logic [RES_W-1:0] res_sat(input logic [RES_W-1:0] q,
                                                input logic ovf, input logic neg);
      logic [RES_W-1:0] r;
      if (neg) begin
         r = (ovf || q > RES_MIN) ? RES_MIN : RES_W'((~q) + RES_W'(1));
      end else begin
         r = (ovf || q[RES_W-1]) ? RES_MAX : q;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/swt_delay.sv -----
// Enabled shift-register delay line, reset clears all stages.
// No dependencies.
`default_nettype none
module swt_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] pipe_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) pipe_ff[i] <= '0;
      end else if (enable) begin
         pipe_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) pipe_ff[i] <= pipe_ff[i-1];
      end
   end

   assign dout = pipe_ff[DEPTH-1];

endmodule
`default_nettype wire

// ----- hw/rtl/swt_div.sv -----
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ovf flags a quotient >= 2^QUO_W. No dependencies.
`default_nettype none
module swt_div #(
   parameter int NUM_W = 48,
   parameter int DEN_W = 31,
   parameter int QUO_W = 32
) (
   input  logic             clock,
   input  logic             enable,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QUO_W-1:0] quo,
   output logic             ovf
);

   logic [NUM_W-1:0] rem_ff [QUO_W];
   logic [DEN_W-1:0] den_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W+1];
   logic             ovf_ff [QUO_W+1];
   logic             fit    [QUO_W];
   logic [NUM_W-1:0] rem_in [QUO_W];
   logic [QUO_W-1:0] quo_in [QUO_W];

   always_comb begin
      for (int s = 0; s < QUO_W; s++) begin
         fit[s]    = (rem_ff[s] >> (QUO_W-1-s)) >= NUM_W'(den_ff[s]);
         rem_in[s] = fit[s] ? rem_ff[s] - (NUM_W'(den_ff[s]) << (QUO_W-1-s)) : rem_ff[s];
         quo_in[s] = quo_ff[s] | (QUO_W'(fit[s]) << (QUO_W-1-s));
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= num;
         den_ff[0] <= den;
         quo_ff[0] <= '0;
         ovf_ff[0] <= (num >> QUO_W) >= NUM_W'(den);
         for (int s = 1; s < QUO_W; s++) begin
            rem_ff[s] <= rem_in[s-1];
            den_ff[s] <= den_ff[s-1];
         end
         for (int s = 1; s <= QUO_W; s++) begin
            quo_ff[s] <= quo_in[s-1];
            ovf_ff[s] <= ovf_ff[s-1];
         end
      end
   end

   assign quo = quo_ff[QUO_W];
   assign ovf = ovf_ff[QUO_W];

endmodule
`default_nettype wire

// ----- hw/rtl/stereo_pixel_world_transform.sv -----
// Stereo pixel/world transform: coefficient store, depth divider, Cramer/projection
// datapath and quotient dividers. Uses swt_pkg, swt_delay, swt_div.
// The result passes through the depth divider (DATA_WIDTH+1 stages), five arithmetic
// stages, the 33-stage quotient dividers and the output register. Throughput one
// word per cycle while rsp_tready does not stall the pipeline.
// Reset clears valid state and the delay lines, not the stage data; coefficient store is undefined until loaded.
`default_nettype none
module stereo_pixel_world_transform #(
   parameter int FRAC_BITS  = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // coef_index[3:0] coef_value[35:4] pixel_x[67:36] pixel_y[99:68]
   // disparity[130:100] world_x[162:131] world_y[194:163] world_z[226:195]
   input  logic [231:0] req_tdata,
   // action[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_x[31:0] out_y[63:32] out_z[95:64]
   output logic [95:0]  rsp_tdata,
   // status[1:0]
   output logic [1:0]   rsp_tuser
);

   localparam int FB   = FRAC_BITS;
   localparam int DW   = DATA_WIDTH;
   localparam int MW   = (DW > 32) ? DW : 32;
   localparam int PW   = MW + 67;
   localparam int RW   = 67;
   localparam int XW   = 65;
   localparam int HW   = XW - 32;
   localparam int DN_W = swt_pkg::COEF_W + FB;
   localparam int BW   = DW + 33;
   localparam int QW   = swt_pkg::RES_W;
   localparam int NXT [3] = '{1, 2, 0};
   localparam int PRV [3] = '{2, 0, 1};
   localparam logic [DW-1:0] D_MIN = {1'b1, {(DW-1){1'b0}}};
   localparam logic [DW-1:0] D_MAX = {1'b0, {(DW-1){1'b1}}};

   function automatic logic signed [DW-1:0] sat_b(input logic signed [BW-1:0] v);
      logic ok;
      ok = (v[BW-1:DW-1] == '0) || (v[BW-1:DW-1] == '1);
      return ok ? v[DW-1:0] : (v[BW-1] ? D_MIN : D_MAX);
   endfunction

   function automatic logic [PW-1:0] mag(input logic [PW-1:0] v);
      return v[PW-1] ? PW'((~v) + PW'(1)) : v;
   endfunction

   logic en, accept;
   assign en         = ~rsp_tvalid | rsp_tready;
   assign req_tready = en;
   assign accept     = req_tvalid & en;

   // entry: store write and snapshot
   swt_pkg::action_type req_action;
   logic [3:0]          req_idx;
   logic [30:0]         req_disp;
   logic [31:0]         store_ff [swt_pkg::STORE_DEPTH];
   logic [31:0]         scale, s_mag;
   logic [DN_W-1:0]     depth_num;
   swt_pkg::item_type   item;

   assign req_action = swt_pkg::action_type'(req_tuser[1:0]);
   assign req_idx    = req_tdata[3:0];
   assign req_disp   = req_tdata[130:100];

   always_ff @(posedge clock) begin
      if (accept && req_action == swt_pkg::ACT_LOAD
          && req_idx < 4'(swt_pkg::STORE_DEPTH)) begin
         store_ff[req_idx] <= req_tdata[35:4];
      end
   end

   assign scale     = store_ff[swt_pkg::SCALE_INDEX];
   assign s_mag     = scale[31] ? (~scale) + 32'd1 : scale;
   assign depth_num = DN_W'(s_mag) << FB;

   always_comb begin
      item.action    = req_action;
      item.disp_zero = (req_disp == '0);
      item.s_neg     = scale[31];
      for (int i = 0; i < swt_pkg::MAT_ENTRIES; i++) item.m[i] = store_ff[i];
      item.px = req_tdata[67:36];
      item.py = req_tdata[99:68];
      item.wx = req_tdata[162:131];
      item.wy = req_tdata[194:163];
      item.wz = req_tdata[226:195];
   end

   logic [DW-1:0]     dq;
   logic              dovf;
   logic              v0;
   swt_pkg::item_type it0;

   swt_div #(.NUM_W(DN_W), .DEN_W(31), .QUO_W(DW)) u_depth_div (
      .clock(clock), .enable(en), .num(depth_num), .den(req_disp), .quo(dq), .ovf(dovf)
   );

   swt_delay #(.WIDTH($bits(swt_pkg::item_type) + 1), .DEPTH(DW + 1)) u_item_dly (
      .clock(clock), .reset(reset), .enable(en),
      .din({req_tvalid, item}), .dout({v0, it0})
   );

   // stage 1: depth saturation
   logic signed [DW-1:0] depth_in, s1_depth_ff;
   swt_pkg::item_type    s1_item_ff;
   logic                 v1_ff;

   always_comb begin
      if (it0.s_neg) depth_in = (dovf || dq > D_MIN) ? D_MIN : DW'(0 - dq);
      else           depth_in = (dovf || dq[DW-1]) ? D_MAX : dq;
   end

   // stage 2: products
   logic signed [DW+31:0] px_in, py_in, px_ff, py_ff;
   logic signed [DW-1:0]  b2_in, b2_ff, s2_depth_ff;
   logic                  depth_zero_in, s2_depth_zero_ff;
   logic signed [63:0]    cp_in [3][3][2];
   logic signed [63:0]    cp_ff [3][3][2];
   logic signed [63:0]    rp_in [2][3];
   logic signed [63:0]    rp_ff [2][3];
   swt_pkg::item_type     s2_item_ff;
   logic                  v2_ff;
   logic [31:0]           wv [3];

   always_comb begin
      wv[0] = s1_item_ff.wx;
      wv[1] = s1_item_ff.wy;
      wv[2] = s1_item_ff.wz;
      px_in = (DW+32)'(s1_depth_ff) * (DW+32)'($signed(s1_item_ff.px));
      py_in = (DW+32)'(s1_depth_ff) * (DW+32)'($signed(s1_item_ff.py));
      b2_in = sat_b(BW'(s1_depth_ff) - BW'($signed(s1_item_ff.m[11])));
      depth_zero_in = (s1_depth_ff == '0);
      for (int k = 0; k < 3; k++) begin
         for (int r = 0; r < 3; r++) begin
            cp_in[k][r][0] = 64'($signed(s1_item_ff.m[NXT[r]*4 + NXT[k]]))
                           * 64'($signed(s1_item_ff.m[PRV[r]*4 + PRV[k]]));
            cp_in[k][r][1] = 64'($signed(s1_item_ff.m[PRV[r]*4 + NXT[k]]))
                           * 64'($signed(s1_item_ff.m[NXT[r]*4 + PRV[k]]));
         end
      end
      for (int i = 0; i < 2; i++) begin
         for (int j = 0; j < 3; j++) begin
            rp_in[i][j] = 64'($signed(s1_item_ff.m[i*4 + j])) * 64'($signed(wv[j]));
         end
      end
   end

   // stage 3: right-hand side, cross products, projection rows
   logic signed [DW-1:0] b0_in, b1_in, b0_ff, b1_ff, s3_b2_ff, s3_depth_ff;
   logic signed [XW-1:0] x_in [3][3];
   logic signed [XW-1:0] x_ff [3][3];
   logic signed [RW-1:0] row_in [2];
   logic signed [RW-1:0] s3_row_ff [2];
   logic [2:0][31:0]     s3_a0_ff;
   swt_pkg::action_type  s3_action_ff;
   logic                 s3_disp_zero_ff, s3_depth_zero_ff, v3_ff;

   always_comb begin
      b0_in = sat_b(BW'(px_ff >>> FB) - BW'($signed(s2_item_ff.m[3])));
      b1_in = sat_b(BW'(py_ff >>> FB) - BW'($signed(s2_item_ff.m[7])));
      for (int k = 0; k < 3; k++) begin
         for (int r = 0; r < 3; r++) x_in[k][r] = XW'(cp_ff[k][r][0]) - XW'(cp_ff[k][r][1]);
      end
      for (int i = 0; i < 2; i++) begin
         row_in[i] = RW'(rp_ff[i][0]) + RW'(rp_ff[i][1]) + RW'(rp_ff[i][2])
                   + (RW'($signed(s2_item_ff.m[i*4 + 3])) <<< FB);
      end
   end

   // stage 4: dot-product terms, cross products split into low and high halves
   logic signed [DW+HW-1:0] bxl_in [3][3];
   logic signed [DW+HW-1:0] bxl_ff [3][3];
   logic signed [DW+HW-1:0] bxh_in [3][3];
   logic signed [DW+HW-1:0] bxh_ff [3][3];
   logic signed [32+HW-1:0] axl_in [3];
   logic signed [32+HW-1:0] axl_ff [3];
   logic signed [32+HW-1:0] axh_in [3];
   logic signed [32+HW-1:0] axh_ff [3];
   logic signed [RW-1:0]    s4_row_ff [2];
   logic signed [DW-1:0]    s4_depth_ff;
   logic signed [DW-1:0]    bv [3];
   swt_pkg::action_type     s4_action_ff;
   logic                    s4_disp_zero_ff, s4_depth_zero_ff, v4_ff;

   always_comb begin
      bv[0] = b0_ff;
      bv[1] = b1_ff;
      bv[2] = s3_b2_ff;
      for (int k = 0; k < 3; k++) begin
         for (int r = 0; r < 3; r++) begin
            bxl_in[k][r] = (DW+HW)'(bv[r])
                         * (DW+HW)'($signed({1'b0, x_ff[k][r][31:0]}));
            bxh_in[k][r] = (DW+HW)'(bv[r])
                         * (DW+HW)'($signed(x_ff[k][r][XW-1:32]));
         end
      end
      for (int r = 0; r < 3; r++) begin
         axl_in[r] = (32+HW)'($signed(s3_a0_ff[r]))
                   * (32+HW)'($signed({1'b0, x_ff[0][r][31:0]}));
         axh_in[r] = (32+HW)'($signed(s3_a0_ff[r]))
                   * (32+HW)'($signed(x_ff[0][r][XW-1:32]));
      end
   end

   // stage 5: determinants
   logic signed [PW-1:0] detk_in [3];
   logic signed [PW-1:0] detk_ff [3];
   logic signed [PW-1:0] det_in, det_ff;
   logic signed [RW-1:0] s5_row_ff [2];
   logic signed [DW-1:0] s5_depth_ff;
   swt_pkg::action_type  s5_action_ff;
   logic                 s5_disp_zero_ff, s5_depth_zero_ff, v5_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         detk_in[k] = ((PW'(bxh_ff[k][0]) + PW'(bxh_ff[k][1]) + PW'(bxh_ff[k][2])) <<< 32)
                    + PW'(bxl_ff[k][0]) + PW'(bxl_ff[k][1]) + PW'(bxl_ff[k][2]);
      end
      det_in = ((PW'(axh_ff[0]) + PW'(axh_ff[1]) + PW'(axh_ff[2])) <<< 32)
             + PW'(axl_ff[0]) + PW'(axl_ff[1]) + PW'(axl_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v0;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_depth_ff      <= depth_in;
         s1_item_ff       <= it0;
         px_ff            <= px_in;
         py_ff            <= py_in;
         b2_ff            <= b2_in;
         s2_depth_ff      <= s1_depth_ff;
         s2_depth_zero_ff <= depth_zero_in;
         cp_ff            <= cp_in;
         rp_ff            <= rp_in;
         s2_item_ff       <= s1_item_ff;
         b0_ff            <= b0_in;
         b1_ff            <= b1_in;
         s3_b2_ff         <= b2_ff;
         s3_depth_ff      <= s2_depth_ff;
         x_ff             <= x_in;
         s3_row_ff        <= row_in;
         s3_a0_ff         <= {s2_item_ff.m[8], s2_item_ff.m[4], s2_item_ff.m[0]};
         s3_action_ff     <= s2_item_ff.action;
         s3_disp_zero_ff  <= s2_item_ff.disp_zero;
         s3_depth_zero_ff <= s2_depth_zero_ff;
         bxl_ff           <= bxl_in;
         bxh_ff           <= bxh_in;
         axl_ff           <= axl_in;
         axh_ff           <= axh_in;
         s4_row_ff        <= s3_row_ff;
         s4_depth_ff      <= s3_depth_ff;
         s4_action_ff     <= s3_action_ff;
         s4_disp_zero_ff  <= s3_disp_zero_ff;
         s4_depth_zero_ff <= s3_depth_zero_ff;
         detk_ff          <= detk_in;
         det_ff           <= det_in;
         s5_row_ff        <= s4_row_ff;
         s5_depth_ff      <= s4_depth_ff;
         s5_action_ff     <= s4_action_ff;
         s5_disp_zero_ff  <= s4_disp_zero_ff;
         s5_depth_zero_ff <= s4_depth_zero_ff;
      end
   end

   // stage 6: operand select and magnitudes into the quotient dividers
   logic [PW+FB-1:0]  div_num [3];
   logic [PW-1:0]     div_den;
   swt_pkg::meta_type meta, mo;
   logic              vo;

   always_comb begin
      meta.action     = s5_action_ff;
      meta.disp_zero  = s5_disp_zero_ff;
      meta.depth_zero = s5_depth_zero_ff;
      meta.singular   = (det_ff == '0);
      if (s5_action_ff == swt_pkg::ACT_BACK) begin
         div_den = mag(det_ff);
         for (int k = 0; k < 3; k++) begin
            div_num[k]  = (PW+FB)'(mag(detk_ff[k])) << FB;
            meta.neg[k] = detk_ff[k][PW-1] ^ det_ff[PW-1];
         end
      end else begin
         div_den = mag(PW'(s5_depth_ff));
         for (int k = 0; k < 2; k++) begin
            div_num[k]  = (PW+FB)'(mag(PW'(s5_row_ff[k])));
            meta.neg[k] = s5_row_ff[k][RW-1] ^ s5_depth_ff[DW-1];
         end
         div_num[2]  = '0;
         meta.neg[2] = 1'b0;
      end
   end

   logic [QW-1:0] q [3];
   logic          qovf [3];

   for (genvar k = 0; k < 3; k++) begin : g_quo
      swt_div #(.NUM_W(PW + FB), .DEN_W(PW), .QUO_W(QW)) u_quo_div (
         .clock(clock), .enable(en), .num(div_num[k]), .den(div_den),
         .quo(q[k]), .ovf(qovf[k])
      );
   end

   swt_delay #(.WIDTH($bits(swt_pkg::meta_type) + 1), .DEPTH(QW + 1)) u_meta_dly (
      .clock(clock), .reset(reset), .enable(en),
      .din({v5_ff, meta}), .dout({vo, mo})
   );

   // result register
   logic [95:0]          rsp_data_in, rsp_data_ff;
   swt_pkg::status_type  rsp_status_in, rsp_status_ff;
   logic                 rsp_tvalid_ff;
   logic [QW-1:0]        res [3];

   always_comb begin
      for (int k = 0; k < 3; k++) res[k] = swt_pkg::res_sat(q[k], qovf[k], mo.neg[k]);
      rsp_data_in   = '0;
      rsp_status_in = swt_pkg::ST_OK;
      unique case (mo.action)
         swt_pkg::ACT_BACK: begin
            if (mo.disp_zero) rsp_status_in = swt_pkg::ST_ZERO_DISP;
            else if (mo.singular) rsp_status_in = swt_pkg::ST_SINGULAR;
            else rsp_data_in = {res[2], res[1], res[0]};
         end
         swt_pkg::ACT_PROJ: begin
            if (mo.disp_zero || mo.depth_zero) rsp_status_in = swt_pkg::ST_ZERO_DISP;
            else rsp_data_in = {32'd0, res[1], res[0]};
         end
         default: begin
            rsp_data_in   = '0;
            rsp_status_in = swt_pkg::ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_tvalid_ff <= 1'b0;
      else if (en) rsp_tvalid_ff <= vo;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule
`default_nettype wire

// ----- test/stereo_pixel_world_transform_checker.sv -----
// Checker for the stereo pixel/world transform: watches the request and response
// streams, predicts each response from its own coefficient store and compares.
// Depends on swt_pkg.
`timescale 1ns / 100ps
module stereo_pixel_world_transform_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [231:0] req_tdata,
   input  logic [1:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [95:0]  rsp_tdata,
   input  logic [1:0]   rsp_tuser,
   output int           error_count,
   output int           pending_count
);

   typedef struct {
      logic [31:0]          x;
      logic [31:0]          y;
      logic [31:0]          z;
      swt_pkg::status_type  st;
   } point_type;

   typedef logic signed [127:0] wide_type;

   localparam int FRAC_W = 16;

   logic signed [31:0] coef_mem [swt_pkg::STORE_DEPTH];
   point_type          point_q[$];

   function automatic logic [31:0] sat32(input wide_type v);
      if (v > 128'sd2147483647) return 32'h7fffffff;
      if (v < -128'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   function automatic wide_type det3(input wide_type a [9]);
      return a[0] * (a[4] * a[8] - a[5] * a[7])
           - a[3] * (a[1] * a[8] - a[2] * a[7])
           + a[6] * (a[1] * a[5] - a[2] * a[4]);
   endfunction

   function automatic point_type transform_point(input logic [1:0] act,
                                                 input logic [231:0] d);
      point_type          p;
      logic [3:0]         idx;
      logic [30:0]        disp;
      longint             s, mag;
      longint unsigned    q;
      wide_type           depth, det, acc;
      wide_type           a [9];
      wide_type           t [9];
      wide_type           b [3];
      wide_type           w [3];
      p.x = '0; p.y = '0; p.z = '0; p.st = swt_pkg::ST_OK;
      idx  = d[3:0];
      disp = d[130:100];
      depth = '0;
      if (act == swt_pkg::ACT_LOAD) begin
         if (idx < swt_pkg::STORE_DEPTH) coef_mem[idx] = d[35:4];
      end else if (act == swt_pkg::ACT_BACK || act == swt_pkg::ACT_PROJ) begin
         if (disp == 0) begin
            p.st = swt_pkg::ST_ZERO_DISP;
         end else begin
            s   = coef_mem[swt_pkg::SCALE_INDEX];
            mag = (s < 0) ? -s : s;
            q   = (longint'(mag) << FRAC_W) / longint'(disp);
            if (s < 0) depth = (q > 64'd2147483648) ? -128'sd2147483648 : -wide_type'(q);
            else depth = (q > 64'd2147483647) ? 128'sd2147483647 : wide_type'(q);
         end
         if (p.st == swt_pkg::ST_OK && act == swt_pkg::ACT_BACK) begin
            for (int i = 0; i < 3; i++)
               for (int j = 0; j < 3; j++) a[i*3+j] = coef_mem[i*4+j];
            b[0] = $signed(sat32(((depth * $signed(d[67:36])) >>> FRAC_W) - coef_mem[3]));
            b[1] = $signed(sat32(((depth * $signed(d[99:68])) >>> FRAC_W) - coef_mem[7]));
            b[2] = $signed(sat32(depth - coef_mem[11]));
            det = det3(a);
            if (det == 0) begin
               p.st = swt_pkg::ST_SINGULAR;
            end else begin
               for (int k = 0; k < 3; k++) begin
                  t = a;
                  for (int i = 0; i < 3; i++) t[i*3+k] = b[i];
                  acc = (det3(t) <<< FRAC_W) / det;
                  if (k == 0) p.x = sat32(acc);
                  else if (k == 1) p.y = sat32(acc);
                  else p.z = sat32(acc);
               end
            end
         end else if (p.st == swt_pkg::ST_OK) begin
            if (depth == 0) begin
               p.st = swt_pkg::ST_ZERO_DISP;
            end else begin
               w[0] = $signed(d[162:131]);
               w[1] = $signed(d[194:163]);
               w[2] = $signed(d[226:195]);
               for (int i = 0; i < 2; i++) begin
                  acc = wide_type'(coef_mem[i*4+3]) <<< FRAC_W;
                  for (int j = 0; j < 3; j++) acc = acc + coef_mem[i*4+j] * w[j];
                  if (i == 0) p.x = sat32(acc / depth);
                  else p.y = sat32(acc / depth);
               end
            end
         end
      end
      return p;
   endfunction

   assign pending_count = point_q.size();

   initial error_count = 0;

   always @(posedge clock) begin
      point_type e;
      if (!reset) begin
         if (req_tvalid && req_tready) point_q.push_back(transform_point(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (point_q.size() == 0) begin
               $display("%0t: unexpected word x=%h y=%h z=%h st=%0d", $time,
                        rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64], rsp_tuser);
               error_count <= error_count + 1;
            end else begin
               e = point_q.pop_front();
               if (rsp_tdata[31:0] !== e.x || rsp_tdata[63:32] !== e.y ||
                   rsp_tdata[95:64] !== e.z || rsp_tuser !== e.st) begin
                  $display("%0t: mismatch exp x=%h y=%h z=%h st=%0d act x=%h y=%h z=%h st=%0d",
                           $time, e.x, e.y, e.z, e.st, rsp_tdata[31:0], rsp_tdata[63:32],
                           rsp_tdata[95:64], rsp_tuser);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end

endmodule

// ----- test/stereo_pixel_world_transform_tb.sv -----
// Testbench top for the stereo pixel/world transform: drives loads, back-projections
// and projections with random gaps and stalls, and gives the verdict.
// Depends on swt_pkg, stereo_pixel_world_transform and its checker.
`timescale 1ns / 100ps
module stereo_pixel_world_transform_tb;

   localparam logic [1:0] ACT_NONE  = 2'd3;
   localparam int         WATCH_LIM = 20000;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [231:0] req_tdata = '0;
   logic [1:0]   req_tuser = swt_pkg::ACT_LOAD;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [95:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   int           error_count, pending_count;
   logic         quiet = 0;
   logic         hold_req = 0;
   logic         hold_done = 0;
   int           idle_cycles = 0;

   always #2 clock = ~clock;

   stereo_pixel_world_transform u_dut (.*);

   stereo_pixel_world_transform_checker u_chk (.*);

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIM) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      @(negedge reset);
      forever begin
         if (hold_req) begin
            rsp_tready <= 0;
            repeat (400) @(posedge clock);
            hold_req = 0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_tready <= 1;
            @(posedge clock);
         end
      end
   end

   task automatic send_word(input logic [1:0] act, input logic [3:0] idx,
                            input logic [31:0] val, input logic [31:0] px,
                            input logic [31:0] py, input logic [30:0] disp,
                            input logic [31:0] wx, input logic [31:0] wy,
                            input logic [31:0] wz);
      req_tvalid <= 1;
      req_tuser  <= act;
      req_tdata  <= {5'b0, wz, wy, wx, disp, py, px, val, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic load_coef(input logic [3:0] idx, input logic [31:0] val);
      send_word(swt_pkg::ACT_LOAD, idx, val, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom);
   endtask

   function automatic logic [31:0] coord_val();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 32'h00ffffff) - 32'h00800000;
         default: return $urandom_range(0, 32'h0fffffff) - 32'h08000000;
      endcase
   endfunction

   function automatic logic [30:0] disp_val();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return $urandom;
         2: return 31'h7fffffff;
         default: return $urandom_range(1, 32'h00ffffff);
      endcase
   endfunction

   task automatic load_matrix(input bit wild);
      for (int i = 0; i < swt_pkg::STORE_DEPTH; i++) begin
         if (wild) load_coef(4'(i), $urandom);
         else if (i == 0 || i == 5 || i == 10)
            load_coef(4'(i), $urandom_range(32'h00010000, 32'h07000000));
         else load_coef(4'(i), $urandom_range(0, 32'h01ffffff) - 32'h01000000);
      end
   endtask

   task automatic compute_word();
      send_word($urandom_range(0, 1) ? swt_pkg::ACT_BACK : swt_pkg::ACT_PROJ, $urandom,
                $urandom, coord_val(), coord_val(), disp_val(), coord_val(), coord_val(),
                coord_val());
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes, singular matrix, ignored loads, unused action
      for (int i = 0; i < swt_pkg::STORE_DEPTH; i++)
         load_coef(4'(i), (i % 5 == 0) ? 32'h00010000 : 0);
      load_coef(4'd13, 32'hffffffff);
      load_coef(4'd15, 32'h80000000);
      send_word(swt_pkg::ACT_BACK, 0, 0, 32'h7fffffff, 32'h80000000, 31'h00010000, 0, 0, 0);
      send_word(swt_pkg::ACT_PROJ, 0, 0, 0, 0, 31'h7fffffff, 32'h7fffffff, 32'h80000000,
                32'h7fffffff);
      send_word(swt_pkg::ACT_BACK, 0, 0, 32'h00010000, 32'h00010000, 31'h0, 0, 0, 0);
      send_word(swt_pkg::ACT_PROJ, 0, 0, 0, 0, 31'h0, 32'h1, 32'h1, 32'h1);
      send_word(ACT_NONE, 4'hf, 32'hffffffff, '1, '1, '1, '1, '1, '1);
      load_coef(4'(swt_pkg::SCALE_INDEX), 32'h00000001);
      send_word(swt_pkg::ACT_PROJ, 0, 0, 0, 0, 31'h7fffffff, 32'h00010000, 0, 0);
      load_coef(4'(swt_pkg::SCALE_INDEX), 32'h80000000);
      send_word(swt_pkg::ACT_BACK, 0, 0, 32'h7fffffff, 32'h7fffffff, 31'h1, 0, 0, 0);
      load_coef(4'(swt_pkg::SCALE_INDEX), 32'h7fffffff);
      send_word(swt_pkg::ACT_PROJ, 0, 0, 0, 0, 31'h1, 32'h7fffffff, 32'h7fffffff,
                32'h7fffffff);
      load_coef(4'd5, 32'h0);
      send_word(swt_pkg::ACT_BACK, 0, 0, 32'h00010000, 32'h00020000, 31'h00010000, 0, 0, 0);
      // random phases
      for (int n = 0; n < 1500; ) begin
         if (n > 1300) quiet = 1;
         if (n >= 400 && !hold_done) begin
            hold_req  = 1;
            hold_done = 1;
         end
         load_matrix($urandom_range(0, 7) == 0);
         n += swt_pkg::STORE_DEPTH;
         repeat ($urandom_range(20, 60)) begin
            case ($urandom_range(0, 19))
               0: load_coef($urandom, $urandom);
               1: send_word(ACT_NONE, $urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom);
               default: compute_word();
            endcase
            n++;
         end
      end
      req_tvalid <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
